### rtl/mle_pkg.sv
// Shared types, line codes and level helpers for the multi-mode line encoder.
package mle_pkg;

   // Line code selector values (the unused code behaves as NRZ-L)
   localparam logic [2:0] CODE_NRZL = 3'd0;
   localparam logic [2:0] CODE_NRZI = 3'd1;
   localparam logic [2:0] CODE_MAN  = 3'd2;
   localparam logic [2:0] CODE_DMAN = 3'd3;
   localparam logic [2:0] CODE_AMI  = 3'd4;
   localparam logic [2:0] CODE_B8ZS = 3'd5;
   localparam logic [2:0] CODE_HDB3 = 3'd6;

   // Zero-run chunk lengths of the two scrambling codes
   localparam int CHUNK_B8ZS = 8;
   localparam int CHUNK_HDB3 = 4;

   // Line levels, two-bit two's complement
   localparam logic signed [1:0] LV_ZERO = 2'sb00;
   localparam logic signed [1:0] LV_POS  = 2'sb01;
   localparam logic signed [1:0] LV_NEG  = 2'sb11;

   // Most symbols one data bit can release
   localparam int MAX_RESULTS = 8;
   localparam int IDX_W       = $clog2(MAX_RESULTS);
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

   typedef struct packed {
      logic              final_sym;
      logic signed [1:0] second_half;
      logic signed [1:0] first_half;
   } mle_sym_type;

   // Polarity and level state of the coder
   typedef struct packed {
      logic last_pulse_positive;
      logic pulse_seen;
      logic pulse_parity;
      logic current_level;
   } mle_flags_type;

   localparam mle_flags_type FLAGS_RESET = '{
      last_pulse_positive: 1'b0,
      pulse_seen:          1'b0,
      pulse_parity:        1'b0,
      current_level:       1'b1
   };

   // Symbols released by one data bit, in line order, and how many
   typedef struct packed {
      mle_sym_type [MAX_RESULTS-1:0] syms;
      logic [CNT_W-1:0]              count;
   } mle_burst_type;

   function automatic logic signed [1:0] pol(input logic positive);
      return positive ? LV_POS : LV_NEG;
   endfunction

   function automatic mle_sym_type mk_sym(input logic signed [1:0] a,
                                          input logic signed [1:0] b);
      mle_sym_type s;
      s.final_sym   = 1'b0;
      s.first_half  = a;
      s.second_half = b;
      return s;
   endfunction

endpackage

### rtl/mle_step.sv
// Combinational next-state and symbol burst for one data bit.
module mle_step
   import mle_pkg::*;
#(
   parameter int HOLD_DEPTH = 8,
   localparam int HW = $clog2(HOLD_DEPTH + 1)
) (
   input  logic [2:0]      line_code,
   input  logic            data_bit,
   input  logic            end_of_seq,
   input  logic [HW-1:0]   held_cur,
   input  mle_flags_type   flags_cur,
   output logic [HW-1:0]   held_nxt,
   output mle_flags_type   flags_nxt,
   output mle_burst_type   burst
);

   localparam int SW = HW + 2;

   mle_sym_type [MAX_RESULTS-1:0] body;
   logic [CNT_W-1:0]              body_len;
   logic [HW-1:0]                 chunk;
   logic [HW-1:0]                 held_w;
   logic [HW-1:0]                 lead;
   logic [HW-1:0]                 tail;
   logic [HW:0]                   run;
   logic [SW-1:0]                 total;
   logic [SW-1:0]                 ii;
   logic [SW-1:0]                 lead_x;
   logic [CNT_W-1:0]              count;
   logic                          scramble;
   logic                          pre_release;
   logic                          lvl;
   logic                          r;
   logic                          p;

   always_comb begin
      body     = '0;
      body_len = '0;
      flags_nxt = flags_cur;
      lvl = 1'b0;
      r   = 1'b0;
      p   = 1'b0;
      run = '0;

      case (line_code)
         CODE_B8ZS: chunk = HW'(CHUNK_B8ZS);
         CODE_HDB3: chunk = HW'(CHUNK_HDB3);
         default:   chunk = '0;
      endcase
      scramble = (line_code == CODE_B8ZS) || (line_code == CODE_HDB3);

      // Release held zeros first when the current code cannot use them
      pre_release = (held_cur != '0) && (!scramble || held_cur >= chunk);
      held_w      = pre_release ? '0 : held_cur;
      lead        = pre_release ? held_cur : '0;
      held_nxt    = held_w;

      case (line_code)
         CODE_NRZI: begin
            lvl = flags_cur.current_level ^ data_bit;
            flags_nxt.current_level = lvl;
            body[0]  = mk_sym(pol(lvl), pol(lvl));
            body_len = CNT_W'(1);
         end
         CODE_MAN: begin
            body[0]  = mk_sym(pol(data_bit), pol(!data_bit));
            body_len = CNT_W'(1);
         end
         CODE_DMAN: begin
            lvl = data_bit ? flags_cur.current_level : !flags_cur.current_level;
            flags_nxt.current_level = !lvl;
            body[0]  = mk_sym(pol(lvl), pol(!lvl));
            body_len = CNT_W'(1);
         end
         CODE_AMI: begin
            body_len = CNT_W'(1);
            if (data_bit) begin
               p = !flags_cur.last_pulse_positive;
               flags_nxt.last_pulse_positive = p;
               flags_nxt.pulse_seen          = 1'b1;
               flags_nxt.pulse_parity        = !flags_cur.pulse_parity;
               body[0] = mk_sym(pol(p), pol(p));
            end else begin
               body[0] = mk_sym(LV_ZERO, LV_ZERO);
            end
         end
         CODE_B8ZS, CODE_HDB3: begin
            r = flags_cur.pulse_seen ? flags_cur.last_pulse_positive : 1'b1;
            if (data_bit) begin
               // Broken run: release held zeros, then the data pulse
               lead     = lead + held_w;
               held_nxt = '0;
               p = !flags_cur.last_pulse_positive;
               flags_nxt.last_pulse_positive = p;
               flags_nxt.pulse_seen          = 1'b1;
               flags_nxt.pulse_parity        = !flags_cur.pulse_parity;
               body[0]  = mk_sym(pol(p), pol(p));
               body_len = CNT_W'(1);
            end else begin
               run = {1'b0, held_w} + (HW+1)'(1);
               if (run < {1'b0, chunk}) begin
                  held_nxt = HW'(run);
               end else begin
                  held_nxt = '0;
                  if (line_code == CODE_B8ZS) begin
                     // 000VB0VB
                     body[3]  = mk_sym(pol(r), pol(r));
                     body[4]  = mk_sym(pol(!r), pol(!r));
                     body[6]  = mk_sym(pol(!r), pol(!r));
                     body[7]  = mk_sym(pol(r), pol(r));
                     body_len = CNT_W'(CHUNK_B8ZS);
                  end else if (flags_cur.pulse_parity) begin
                     // 000V
                     body[3]  = mk_sym(pol(r), pol(r));
                     body_len = CNT_W'(CHUNK_HDB3);
                     flags_nxt.last_pulse_positive = r;
                     flags_nxt.pulse_seen          = 1'b1;
                     flags_nxt.pulse_parity        = !flags_cur.pulse_parity;
                  end else begin
                     // B00V
                     p = flags_cur.pulse_seen ? !r : 1'b1;
                     body[0]  = mk_sym(pol(p), pol(p));
                     body[3]  = mk_sym(pol(p), pol(p));
                     body_len = CNT_W'(CHUNK_HDB3);
                     flags_nxt.last_pulse_positive = p;
                     flags_nxt.pulse_seen          = 1'b1;
                  end
               end
            end
         end
         default: begin
            body[0]  = mk_sym(pol(data_bit), pol(data_bit));
            body_len = CNT_W'(1);
         end
      endcase

      // Last bit: drain what is still held and start over
      tail = end_of_seq ? held_nxt : '0;
      if (end_of_seq) begin
         held_nxt  = '0;
         flags_nxt = FLAGS_RESET;
      end

      total = SW'(lead) + SW'(body_len) + SW'(tail);
      count = (total > SW'(MAX_RESULTS)) ? CNT_W'(MAX_RESULTS) : CNT_W'(total);

      // Place the body behind the leading zeros; drained zeros follow it
      lead_x = SW'(lead);
      burst.count = count;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         ii = SW'(i);
         burst.syms[i] = mk_sym(LV_ZERO, LV_ZERO);
         if (ii >= lead_x) begin
            burst.syms[i] = body[IDX_W'(ii - lead_x)];
         end
         if (end_of_seq && (CNT_W'(i + 1) == count)) begin
            burst.syms[i].final_sym = 1'b1;
         end
      end
   end

endmodule

### rtl/multi_mode_line_encoder.sv
// Top level of the multi-mode line encoder: handshakes, state and result queue.
//
// Usage
//   req_* : one data bit per transaction (req_tdata[0]); req_tlast marks the
//           final bit of a sequence and drains any held zeros.
//   rsp_* : one line symbol per transaction, first and second half levels as
//           two-bit signed values (-1, 0, +1); rsp_tlast marks the symbol of
//           the final data bit.
//   csr_* : write the line code (0 NRZ-L, 1 NRZ-I, 2 Manchester, 3 diff
//           Manchester, 4 AMI, 5 B8ZS, 6 HDB3) only while the block is idle.
// Output: the first symbol of a bit is presented in the cycle after the bit's
//   transaction. Throughput: one bit per cycle while each bit yields at most
//   one symbol and the receiver does not stall; a bit releasing more than one
//   symbol (up to eight, a B8ZS substitution or a drained run) holds the input
//   until its last symbol leaves the one-symbol-per-cycle output queue. Bits
//   held inside a zero run yield no symbol and go at one per cycle.
// Reset (synchronous, active high) empties the queue, clears the run count,
//   sets polarity to "no pulse yet" and the NRZ level to one; line code 0.
// A stalled receiver holds the head symbol; a new bit is taken only when the
//   queue is empty or its last symbol leaves in the same cycle.
module multi_mode_line_encoder
   import mle_pkg::*;
#(
   parameter int HOLD_DEPTH = 8
) (
   input  logic       clock,
   input  logic       reset,
   // Request: [0] data_bit
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tlast,
   // Response: [1:0] first_half, [3:2] second_half
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,
   output logic       rsp_tlast,
   // Line code register
   input  logic       csr_wr_en,
   input  logic [2:0] csr_wr_data
);

   localparam int HW = $clog2(HOLD_DEPTH + 1);

   // Held symbols are always zero levels, so a count stands for the delay store
   logic [HW-1:0]                 held_ff, held_in;
   mle_flags_type                 flags_ff, flags_in;
   logic [2:0]                    line_code_ff, line_code_in;
   mle_sym_type [MAX_RESULTS-1:0] queue_ff, queue_in;
   logic [CNT_W-1:0]              count_ff, count_in;

   logic          req_accept;
   logic          rsp_accept;
   logic [HW-1:0] held_nxt;
   mle_flags_type flags_nxt;
   mle_burst_type burst;

   mle_step #(
      .HOLD_DEPTH (HOLD_DEPTH)
   ) u_step (
      .line_code  (line_code_ff),
      .data_bit   (req_tdata[0]),
      .end_of_seq (req_tlast),
      .held_cur   (held_ff),
      .flags_cur  (flags_ff),
      .held_nxt   (held_nxt),
      .flags_nxt  (flags_nxt),
      .burst      (burst)
   );

   // Take a new bit when the queue is empty or drains this cycle
   assign req_tready = (count_ff == '0) || ((count_ff == CNT_W'(1)) && rsp_tready);
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = (count_ff != '0);
   assign rsp_accept = rsp_tvalid && rsp_tready;

   // The head of the queue is the output register
   assign rsp_tdata = {4'b0000, queue_ff[0].second_half, queue_ff[0].first_half};
   assign rsp_tlast = queue_ff[0].final_sym;

   always_comb begin
      held_in      = held_ff;
      flags_in     = flags_ff;
      line_code_in = csr_wr_en ? csr_wr_data : line_code_ff;
      queue_in     = queue_ff;
      count_in     = count_ff;

      // Advance the queue by one symbol per response transaction
      if (rsp_accept) begin
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            queue_in[i] = queue_ff[i + 1];
         end
         count_in = count_ff - CNT_W'(1);
      end

      // Load the burst of a new bit; the old queue is empty by now
      if (req_accept) begin
         held_in  = held_nxt;
         flags_in = flags_nxt;
         queue_in = burst.syms;
         count_in = burst.count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= '0;
         flags_ff     <= FLAGS_RESET;
         line_code_ff <= CODE_NRZL;
         count_ff     <= '0;
      end else begin
         held_ff      <= held_in;
         flags_ff     <= flags_in;
         line_code_ff <= line_code_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      queue_ff <= queue_in;
   end

   // A new bit never lands on a queue with symbols still waiting behind the head
   a_accept_drained: assert property (@(posedge clock) disable iff (reset)
      req_accept |-> (count_ff <= CNT_W'(1)))
      else $error("bit accepted over a pending burst");

   // A zero run never reaches a full B8ZS chunk without being substituted
   a_held_bound: assert property (@(posedge clock) disable iff (reset)
      held_ff < HW'(CHUNK_B8ZS))
      else $error("held zero count out of range");

   // The final marker only ever sits on the last queued symbol
   a_last_at_tail: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> (count_ff == CNT_W'(1)))
      else $error("final symbol not at end of burst");

   // The final bit of a sequence leaves the coder in its reset state
   a_eos_clears: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tlast) |=> ((held_ff == '0) && (flags_ff == FLAGS_RESET)))
      else $error("state not cleared after final bit");

endmodule

### verif/multi_mode_line_encoder_tb.sv
// Self-checking testbench for the multi-mode line encoder: directed and random bit streams.
module multi_mode_line_encoder_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mle_pkg::*;

   localparam int ZERO_STORE_DEPTH = 8;
   localparam int REPORT_LIMIT     = 10;
   localparam int RANDOM_BITS      = 410;
   localparam int DRAIN_CYCLES     = 4;

   // Drive every input to a known value from time zero
   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_tvalid  = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata   = 8'd0;   // [0] data_bit, [7:1] zero
   logic       req_tlast   = 1'b0;   // end_of_sequence
   logic       rsp_tvalid;
   logic       rsp_tready  = 1'b0;
   logic [7:0] rsp_tdata;            // [1:0] first_half, [3:2] second_half
   logic       rsp_tlast;            // final_symbol
   logic       csr_wr_en   = 1'b0;
   logic [2:0] csr_wr_data = 3'd0;

   // Line coder shadow state
   logic [2:0]        coder_mode;
   logic signed [1:0] zero_hold [ZERO_STORE_DEPTH];
   int                zeros_held;
   int                run_len;
   logic              last_pos;
   logic              pulse_seen_q;
   logic              pulse_odd;
   logic              nrz_level;

   // Symbols released by the bit being encoded, then the line symbols still owed
   mle_sym_type released [$];
   mle_sym_type symbols_due [$];
   mle_sym_type due;

   int  error_count     = 0;
   int  symbols_checked = 0;
   int  bits_sent       = 0;
   int  sequences_run   = 0;
   int  substitutions   = 0;
   int  stall_left      = 0;
   bit  steady_phase    = 1'b0;

   multi_mode_line_encoder u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------- prediction

   function automatic logic signed [1:0] level_of(input logic positive);
      return positive ? LV_POS : LV_NEG;
   endfunction

   // Append one symbol; a single bit never releases more than MAX_RESULTS
   function automatic void add_sym(input logic signed [1:0] a, input logic signed [1:0] b);
      mle_sym_type s;
      if (released.size() < MAX_RESULTS) begin
         s.first_half  = a;
         s.second_half = b;
         s.final_sym   = 1'b0;
         released.push_back(s);
      end
   endfunction

   // Release held zeros as plain zero symbols and restart the run
   function automatic void flush_held();
      for (int i = 0; i < zeros_held && i < ZERO_STORE_DEPTH; i++)
         add_sym(zero_hold[i], zero_hold[i]);
      zeros_held = 0;
      run_len    = 0;
   endfunction

   // Alternate mark: each data pulse flips polarity and pulse parity
   function automatic void ami_pulse();
      logic pp;
      pp           = !last_pos;
      last_pos     = pp;
      pulse_seen_q = 1'b1;
      pulse_odd    = !pulse_odd;
      add_sym(level_of(pp), level_of(pp));
   endfunction

   // Return polarity, parity, NRZ level and the zero store to reset values
   function automatic void clear_coder();
      foreach (zero_hold[i]) zero_hold[i] = LV_ZERO;
      zeros_held   = 0;
      run_len      = 0;
      last_pos     = 1'b0;
      pulse_seen_q = 1'b0;
      pulse_odd    = 1'b0;
      nrz_level    = 1'b1;
   endfunction

   // Encode one accepted bit and queue the symbols it releases
   function automatic void encode_bit(input logic d, input logic eos);
      int          chunk;
      logic        r;
      logic        p;
      logic        f;
      mle_sym_type s;
      released.delete();
      chunk = (coder_mode == CODE_B8ZS) ? CHUNK_B8ZS :
              (coder_mode == CODE_HDB3) ? CHUNK_HDB3 : 0;
      // Held zeros left over from a previous code go out first
      if (zeros_held > 0 && (chunk == 0 || zeros_held >= chunk))
         flush_held();
      case (coder_mode)
         CODE_NRZI: begin
            if (d) nrz_level = !nrz_level;
            add_sym(level_of(nrz_level), level_of(nrz_level));
         end
         CODE_MAN: begin
            add_sym(level_of(d), level_of(!d));
         end
         CODE_DMAN: begin
            f = d ? nrz_level : !nrz_level;
            add_sym(level_of(f), level_of(!f));
            nrz_level = !f;
         end
         CODE_AMI: begin
            if (d) ami_pulse();
            else add_sym(LV_ZERO, LV_ZERO);
         end
         CODE_B8ZS, CODE_HDB3: begin
            if (d) begin
               flush_held();
               ami_pulse();
            end else begin
               run_len = (run_len + 1) & 15;
               if (run_len < chunk) begin
                  if (zeros_held < ZERO_STORE_DEPTH) zero_hold[zeros_held] = LV_ZERO;
                  zeros_held++;
               end else begin
                  // Whole chunk of zeros: substitute
                  zeros_held = 0;
                  run_len    = 0;
                  substitutions++;
                  r = pulse_seen_q ? last_pos : 1'b1;
                  if (coder_mode == CODE_B8ZS) begin
                     add_sym(LV_ZERO, LV_ZERO);
                     add_sym(LV_ZERO, LV_ZERO);
                     add_sym(LV_ZERO, LV_ZERO);
                     add_sym(level_of(r), level_of(r));
                     add_sym(level_of(!r), level_of(!r));
                     add_sym(LV_ZERO, LV_ZERO);
                     add_sym(level_of(!r), level_of(!r));
                     add_sym(level_of(r), level_of(r));
                  end else if (pulse_odd) begin
                     // Odd pulse count: 000V
                     add_sym(LV_ZERO, LV_ZERO);
                     add_sym(LV_ZERO, LV_ZERO);
                     add_sym(LV_ZERO, LV_ZERO);
                     add_sym(level_of(r), level_of(r));
                     last_pos     = r;
                     pulse_seen_q = 1'b1;
                     pulse_odd    = !pulse_odd;
                  end else begin
                     // Even pulse count: B00V, positive when no pulse came yet
                     p = pulse_seen_q ? !r : 1'b1;
                     add_sym(level_of(p), level_of(p));
                     add_sym(LV_ZERO, LV_ZERO);
                     add_sym(LV_ZERO, LV_ZERO);
                     add_sym(level_of(p), level_of(p));
                     last_pos     = p;
                     pulse_seen_q = 1'b1;
                  end
               end
            end
         end
         default: begin
            // NRZ-L, and the unused code acts the same
            add_sym(level_of(d), level_of(d));
         end
      endcase
      // End of sequence: drain the store, flag the last symbol, clear the state
      if (eos) begin
         flush_held();
         if (released.size() > 0) begin
            s = released[released.size() - 1];
            s.final_sym = 1'b1;
            released[released.size() - 1] = s;
         end
         clear_coder();
      end
      foreach (released[i]) symbols_due.push_back(released[i]);
   endfunction

   // ---------------------------------------------------------------- helpers

   task automatic report_error(input string msg);
      error_count++;
      if (error_count <= REPORT_LIMIT) $display("%s", msg);
   endtask

   // Idle length: mostly none or short, now and then long; none in a steady phase
   function automatic int pick_gap();
      int unsigned r;
      if (steady_phase) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 20);
   endfunction

   // Send one data bit; called and returning at a falling edge with valid held high
   task automatic send_bit(input logic d, input logic eos);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, d};
      req_tlast  <= eos;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      encode_bit(d, eos);
      bits_sent++;
      @(negedge clock);
   endtask

   // Drop valid, wait for every owed symbol, then let held-zero bits settle
   task automatic wait_quiet();
      req_tvalid <= 1'b0;
      while (symbols_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Write the line code register; only call while the block is idle
   task automatic write_line_code(input logic [2:0] code);
      wait_quiet();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= code;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      coder_mode  = code;
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------- checking

   // Compare each symbol transaction against the oldest owed symbol
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (symbols_due.size() == 0) begin
            report_error($sformatf("%0t: unexpected symbol first=%0d second=%0d last=%0b",
                                   $realtime, $signed(rsp_tdata[1:0]),
                                   $signed(rsp_tdata[3:2]), rsp_tlast));
         end else begin
            due = symbols_due.pop_front();
            symbols_checked++;
            if (rsp_tdata[1:0] !== due.first_half || rsp_tdata[3:2] !== due.second_half ||
                rsp_tlast !== due.final_sym)
               report_error({
                  $sformatf("%0t: symbol %0d mismatch: expected first=%0d second=%0d last=%0b",
                            $realtime, symbols_checked, due.first_half, due.second_half,
                            due.final_sym),
                  $sformatf(", got first=%0d second=%0d last=%0b",
                            $signed(rsp_tdata[1:0]), $signed(rsp_tdata[3:2]), rsp_tlast)});
         end
      end
   end

   // Receiver back-pressure: random stalls, none during a steady phase
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         stall_left = pick_gap();
      end
   end

   // ---------------------------------------------------------------- tests

   // Short sequences through every non-scrambling code, extremes 0 and 7 included
   task automatic test_plain_codes();
      write_line_code(CODE_NRZL);
      send_bit(1'b1, 1'b0);
      send_bit(1'b0, 1'b1);
      write_line_code(3'd7);
      send_bit(1'b1, 1'b0);
      send_bit(1'b0, 1'b1);
      write_line_code(CODE_NRZI);
      send_bit(1'b1, 1'b0);
      send_bit(1'b0, 1'b1);
      write_line_code(CODE_MAN);
      send_bit(1'b1, 1'b0);
      send_bit(1'b0, 1'b1);
      write_line_code(CODE_DMAN);
      send_bit(1'b1, 1'b0);
      send_bit(1'b0, 1'b1);
      write_line_code(CODE_AMI);
      send_bit(1'b1, 1'b0);
      send_bit(1'b1, 1'b0);
      send_bit(1'b0, 1'b1);
   endtask

   // HDB3: even parity with no pulse yet, then odd parity after one mark
   task automatic test_hdb3_substitution();
      write_line_code(CODE_HDB3);
      repeat (4) send_bit(1'b0, 1'b0);
      send_bit(1'b1, 1'b0);
      repeat (3) send_bit(1'b0, 1'b0);
      send_bit(1'b0, 1'b1);
   endtask

   // Held zeros across a code change must come out before the next symbol
   task automatic test_mode_change_release();
      write_line_code(CODE_B8ZS);
      send_bit(1'b0, 1'b0);
      send_bit(1'b0, 1'b0);
      write_line_code(CODE_AMI);
      send_bit(1'b1, 1'b1);
   endtask

   // Random sequences; scrambling codes get zero runs shaped around the chunk size
   task automatic test_random_sequences();
      int unsigned pick;
      logic [2:0]  code;
      int          len;
      int          chunk;
      int          run;
      bit          ends;
      bit          seq_bits [$];
      while (bits_sent < RANDOM_BITS) begin
         pick = $urandom_range(0, 9);
         code = (pick == 8) ? CODE_B8ZS : (pick == 9) ? CODE_HDB3 : pick[2:0];
         len  = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 48) : $urandom_range(1, 20);
         ends = ($urandom_range(0, 3) != 0);
         chunk = (code == CODE_B8ZS) ? CHUNK_B8ZS : (code == CODE_HDB3) ? CHUNK_HDB3 : 0;
         seq_bits.delete();
         while (seq_bits.size() < len) begin
            if (chunk == 0 || $urandom_range(0, 2) == 0) begin
               seq_bits.push_back((chunk == 0) ? 1'($urandom_range(0, 1)) : 1'b1);
            end else begin
               case ($urandom_range(0, 4))
                  0:       run = chunk - 1;
                  1:       run = chunk;
                  2:       run = chunk + $urandom_range(1, chunk - 1);
                  3:       run = 2 * chunk;
                  default: run = $urandom_range(1, 3);
               endcase
               repeat (run) seq_bits.push_back(1'b0);
            end
         end
         // Settle first, then pick this sequence's pacing
         write_line_code(code);
         steady_phase = ($urandom_range(0, 4) == 0);
         foreach (seq_bits[i])
            send_bit(seq_bits[i], ends && (i == seq_bits.size() - 1));
         sequences_run++;
      end
   endtask

   // ---------------------------------------------------------------- run control

   initial begin
      coder_mode = CODE_NRZL;
      clear_coder();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_plain_codes();
      test_hdb3_substitution();
      test_mode_change_release();
      test_random_sequences();
      // Drain, then hold a little longer so stray symbols get caught
      steady_phase = 1'b0;
      wait_quiet();
      repeat (20) @(negedge clock);
      $display("Covered %0d data bits (%0d random sequences) over line codes 0 to 7,",
               bits_sent, sequences_run);
      $display("checked %0d line symbols including %0d zero-run substitutions; %0d mismatches.",
               symbols_checked, substitutions, error_count);
      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("Timeout with %0d symbols still owed", symbols_due.size());
      $display("TEST FAILED");
      $finish;
   end

endmodule
